// File: rtl/hdpq_pkg.sv
package hdpq_pkg;

	localparam int NUM_USERS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;

	localparam logic [15:0] DEADLINE_OFFSET_RST = 16'd10;
	localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd4;

	localparam logic [1:0] CFG_DEADLINE_OFFSET = 2'd0;
	localparam logic [1:0] CFG_RETRY_LIMIT     = 2'd1;

	localparam logic [1:0] OP_ARRIVAL  = 2'd0;
	localparam logic [1:0] OP_FEEDBACK = 2'd1;
	localparam logic [1:0] OP_EXPIRE   = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	localparam logic [2:0] OUT_QUEUED       = 3'd0;
	localparam logic [2:0] OUT_ARRIVAL_FULL = 3'd1;
	localparam logic [2:0] OUT_DELIVERED    = 3'd2;
	localparam logic [2:0] OUT_REQUEUED     = 3'd3;
	localparam logic [2:0] OUT_RETRY_DROP   = 3'd4;
	localparam logic [2:0] OUT_REQUEUE_FULL = 3'd5;
	localparam logic [2:0] OUT_EXPIRED      = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CTRL,
		ST_EXP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] bits;
		logic [31:0] arrival;
		logic [31:0] deadline;
	} pkt_t;

endpackage

// File: rtl/hdpq_ram.sv
module hdpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/harq_deadline_packet_queue_manager.sv
// Per-user packet deque manager with HARQ requeue and deadline expiry.
// Command channel: an item is taken when start is high and busy is low.
// Items for a user at or above NUM_USERS, or with the unused operation
// code, are taken and dropped in the same cycle without a result.
// Arrival and feedback give one result, registered from the control state;
// busy is high for one cycle, and no new item is taken until it falls.
// Expire reads one head packet per cycle from the packet memory and
// removes at most 16 per item, stopping at the first head that has not
// expired or when the queue runs empty.
// Results appear on result_valid for one cycle each; last_result marks
// the final one of an item. The receiver cannot stall, so no buffering.
// Config: cfg_valid/cfg_ready write channel, always ready; index 0 is the
// deadline offset, index 1 the retry limit, other indexes are ignored.
// Write config only while busy is low and no results are pending.
// Reset clears the per-user head and fill state at once through valid
// bits; packet memory content is never read before it is written.
module harq_deadline_packet_queue_manager #(
	parameter int NUM_USERS   = hdpq_pkg::NUM_USERS_DEF,
	parameter int QUEUE_DEPTH = hdpq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [3:0]  user_index,
	input  logic [31:0] now_tick,
	input  logic [15:0] packet_bits,
	input  logic [31:0] packet_arrival_tick,
	input  logic [31:0] packet_deadline_tick,
	input  logic        acknowledged,
	input  logic [3:0]  retry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  outcome,
	output logic [3:0]  out_user,
	output logic [15:0] out_bits,
	output logic [31:0] out_arrival_tick,
	output logic [31:0] out_deadline_tick,
	output logic [4:0]  queue_fill,
	output logic        last_result
);

	localparam int UW  = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int HW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int PD  = NUM_USERS * QUEUE_DEPTH;
	localparam int PAW = $clog2(PD);
	localparam int CW  = HW + FW;
	localparam int NW  = $clog2(hdpq_pkg::MAX_RESULTS + 1);
	localparam int PW  = $bits(hdpq_pkg::pkt_t);

	hdpq_pkg::state_t state_q, state_d;

	logic [15:0] offset_q;
	logic [3:0]  retry_lim_q;

	logic [1:0]  op_q;
	logic [3:0]  user_q;
	logic [31:0] now_q;
	logic [15:0] bits_q;
	logic [31:0] parr_q;
	logic [31:0] pdl_q;
	logic        ack_q;
	logic [3:0]  retry_q;

	logic [HW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [NW-1:0] n_q;
	logic          pend_q;
	hdpq_pkg::pkt_t pend_pkt_q;
	logic [FW-1:0]  pend_fill_q;

	logic [NUM_USERS-1:0] ctrl_vld_q;

	logic          accept, item_ok;
	logic [UW-1:0] uaddr_q, uaddr_in;
	logic [PAW-1:0] base;

	logic          ctrl_we;
	logic [CW-1:0] ctrl_wdata, ctrl_rdata;
	logic [HW-1:0] head_c, head_inc, head_dec, head_w;
	logic [FW-1:0] fill_c, fill_w;
	logic [HW:0]   tail_sum;
	logic [HW-1:0] tail_idx;
	logic [31:0]   dl_new;

	logic           pkt_we, pkt_re;
	logic [PAW-1:0] pkt_waddr, pkt_raddr;
	hdpq_pkg::pkt_t pkt_wdata, pkt_rdata;

	logic           expired, more;
	logic           emit;
	logic [2:0]     emit_outcome;
	hdpq_pkg::pkt_t emit_pkt;
	logic [FW-1:0]  emit_fill;
	logic           emit_last;
	logic           load_work, pend_load;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != hdpq_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign uaddr_in  = UW'(user_index);
	assign uaddr_q   = UW'(user_q);
	assign item_ok   = (32'(user_index) < NUM_USERS) && (operation != hdpq_pkg::OP_NONE);
	assign base      = PAW'(32'(uaddr_q) * QUEUE_DEPTH);

	hdpq_ram #(.WIDTH(CW), .DEPTH(NUM_USERS)) u_ctrl_ram (
		.clk   (clk),
		.we    (ctrl_we),
		.waddr (uaddr_q),
		.wdata (ctrl_wdata),
		.re    (accept),
		.raddr (uaddr_in),
		.rdata (ctrl_rdata)
	);

	hdpq_ram #(.WIDTH(PW), .DEPTH(PD)) u_pkt_ram (
		.clk   (clk),
		.we    (pkt_we),
		.waddr (pkt_waddr),
		.wdata (pkt_wdata),
		.re    (pkt_re),
		.raddr (pkt_raddr),
		.rdata (pkt_rdata)
	);

	// per-user state, zero until first written
	assign head_c = ctrl_vld_q[uaddr_q] ? ctrl_rdata[CW-1:FW] : '0;
	assign fill_c = ctrl_vld_q[uaddr_q] ? ctrl_rdata[FW-1:0] : '0;

	always_comb begin
		logic [HW-1:0] h;
		h = (state_q == hdpq_pkg::ST_CTRL) ? head_c : head_q;
		head_inc = (32'(h) == QUEUE_DEPTH - 1) ? '0 : h + HW'(1);
		head_dec = (h == '0) ? HW'(QUEUE_DEPTH - 1) : h - HW'(1);
	end

	always_comb begin
		tail_sum = (HW+1)'(head_c) + (HW+1)'(fill_c);
		if (32'(tail_sum) >= QUEUE_DEPTH) begin
			tail_idx = HW'(tail_sum - (HW+1)'(QUEUE_DEPTH));
		end else begin
			tail_idx = HW'(tail_sum);
		end
	end

	assign dl_new  = now_q + 32'(offset_q);
	assign expired = pkt_rdata.deadline < now_q;
	assign more    = (fill_q > FW'(1)) && (n_q < NW'(hdpq_pkg::MAX_RESULTS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hdpq_pkg::ST_IDLE: begin
				if (accept && item_ok) begin
					state_d = hdpq_pkg::ST_CTRL;
				end
			end
			hdpq_pkg::ST_CTRL: begin
				if (op_q == hdpq_pkg::OP_EXPIRE && fill_c != '0) begin
					state_d = hdpq_pkg::ST_EXP;
				end else begin
					state_d = hdpq_pkg::ST_IDLE;
				end
			end
			hdpq_pkg::ST_EXP: begin
				if (!expired) begin
					state_d = hdpq_pkg::ST_IDLE;
				end else if (!more) begin
					state_d = hdpq_pkg::ST_FIN;
				end
			end
			hdpq_pkg::ST_FIN: state_d = hdpq_pkg::ST_IDLE;
			default: state_d = hdpq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl_we      = 1'b0;
		head_w       = head_q;
		fill_w       = fill_q;
		pkt_we       = 1'b0;
		pkt_waddr    = base + PAW'(tail_idx);
		pkt_wdata    = '{bits: bits_q, arrival: now_q, deadline: dl_new};
		pkt_re       = 1'b0;
		pkt_raddr    = base + PAW'(head_inc);
		emit         = 1'b0;
		emit_outcome = hdpq_pkg::OUT_EXPIRED;
		emit_pkt     = pend_pkt_q;
		emit_fill    = pend_fill_q;
		emit_last    = 1'b1;
		load_work    = 1'b0;
		pend_load    = 1'b0;
		unique case (state_q)
			hdpq_pkg::ST_IDLE: ;
			hdpq_pkg::ST_CTRL: begin
				ctrl_we = 1'b1;
				head_w  = head_c;
				fill_w  = fill_c;
				case (op_q)
					hdpq_pkg::OP_ARRIVAL: begin
						emit     = 1'b1;
						emit_pkt = '{bits: bits_q, arrival: now_q, deadline: dl_new};
						if (32'(fill_c) >= QUEUE_DEPTH) begin
							emit_outcome = hdpq_pkg::OUT_ARRIVAL_FULL;
							emit_fill    = fill_c;
						end else begin
							emit_outcome = hdpq_pkg::OUT_QUEUED;
							pkt_we       = 1'b1;
							fill_w       = fill_c + FW'(1);
							emit_fill    = fill_w;
						end
					end
					hdpq_pkg::OP_FEEDBACK: begin
						emit      = 1'b1;
						emit_pkt  = '{bits: bits_q, arrival: parr_q, deadline: pdl_q};
						emit_fill = fill_c;
						if (ack_q) begin
							emit_outcome = hdpq_pkg::OUT_DELIVERED;
						end else if (retry_q >= retry_lim_q) begin
							emit_outcome = hdpq_pkg::OUT_RETRY_DROP;
						end else if (32'(fill_c) >= QUEUE_DEPTH) begin
							emit_outcome = hdpq_pkg::OUT_REQUEUE_FULL;
						end else begin
							emit_outcome = hdpq_pkg::OUT_REQUEUED;
							pkt_we       = 1'b1;
							pkt_waddr    = base + PAW'(head_dec);
							pkt_wdata    = emit_pkt;
							head_w       = head_dec;
							fill_w       = fill_c + FW'(1);
							emit_fill    = fill_w;
						end
					end
					default: begin
						if (fill_c != '0) begin
							ctrl_we   = 1'b0;
							load_work = 1'b1;
							pkt_re    = 1'b1;
							pkt_raddr = base + PAW'(head_c);
						end
					end
				endcase
			end
			hdpq_pkg::ST_EXP: begin
				if (expired) begin
					emit      = pend_q;
					emit_last = 1'b0;
					pend_load = 1'b1;
					pkt_re    = more;
				end else begin
					emit    = pend_q;
					ctrl_we = 1'b1;
				end
			end
			hdpq_pkg::ST_FIN: begin
				emit    = 1'b1;
				ctrl_we = 1'b1;
			end
			default: ;
		endcase
		ctrl_wdata = {head_w, fill_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hdpq_pkg::ST_IDLE;
			offset_q     <= hdpq_pkg::DEADLINE_OFFSET_RST;
			retry_lim_q  <= hdpq_pkg::RETRY_LIMIT_RST;
			ctrl_vld_q   <= '0;
			pend_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (cfg_valid) begin
				case (cfg_index)
					hdpq_pkg::CFG_DEADLINE_OFFSET: offset_q <= cfg_data;
					hdpq_pkg::CFG_RETRY_LIMIT:     retry_lim_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (ctrl_we) begin
				ctrl_vld_q[uaddr_q] <= 1'b1;
			end
			if (load_work) begin
				pend_q <= 1'b0;
			end else if (pend_load) begin
				pend_q <= 1'b1;
			end else if (emit) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			user_q  <= user_index;
			now_q   <= now_tick;
			bits_q  <= packet_bits;
			parr_q  <= packet_arrival_tick;
			pdl_q   <= packet_deadline_tick;
			ack_q   <= acknowledged;
			retry_q <= retry_count;
		end
		if (load_work) begin
			head_q <= head_c;
			fill_q <= fill_c;
			n_q    <= '0;
		end else if (pend_load) begin
			head_q      <= head_inc;
			fill_q      <= fill_q - FW'(1);
			n_q         <= n_q + NW'(1);
			pend_pkt_q  <= pkt_rdata;
			pend_fill_q <= fill_q - FW'(1);
		end
		if (emit) begin
			outcome           <= emit_outcome;
			out_user          <= user_q;
			out_bits          <= emit_pkt.bits;
			out_arrival_tick  <= emit_pkt.arrival;
			out_deadline_tick <= emit_pkt.deadline;
			queue_fill        <= 5'(emit_fill);
			last_result       <= emit_last;
		end
	end

endmodule
